>>> rtl/mi_pkg.sv
// mi_pkg: command and status types shared by the modular inverse controller and datapath
// no dependencies

package mi_pkg;

	// controller to datapath commands, at most one active per cycle
	typedef struct packed {
		logic load;       // capture a new operand pair and start coefficients
		logic div_init;   // start a long division of r by nr
		logic div_step;   // one restoring division step, one quotient bit
		logic commit;     // apply the finished quotient step to the pair
		logic emit;       // write the result into the output register
	} mi_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic nr_zero;    // remainder reached zero, the gcd is in r
		logic out_free;   // output register can take a result this cycle
	} mi_sts_t;

endpackage

>>> rtl/mi_in_if.sv
// mi_in_if: valid/ready channel carrying an operand pair
// no dependencies

interface mi_in_if #(
	parameter int OPBITS = 31
);
	logic              valid;
	logic              ready;
	logic [OPBITS-1:0] value;
	logic [OPBITS-1:0] modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink   (input valid, input value, input modulus, output ready);
endinterface

>>> rtl/mi_out_if.sv
// mi_out_if: valid/ready channel carrying an inverse and its status
// no dependencies

interface mi_out_if #(
	parameter int OPBITS = 31
);
	logic              valid;
	logic              ready;
	logic [OPBITS-1:0] inverse;
	logic              status;

	modport source (output valid, output inverse, output status, input ready);
	modport sink   (input valid, input inverse, input status, output ready);
endinterface

>>> rtl/mi_datapath.sv
// mi_datapath: remainder/coefficient registers, bit-serial divider and output register
// depends on mi_pkg

module mi_datapath #(
	parameter int OPBITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mi_pkg::mi_cmd_t     cmd,
	output mi_pkg::mi_sts_t     sts,
	input  logic [OPBITS-1:0]   value,
	input  logic [OPBITS-1:0]   modulus,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [OPBITS-1:0]   inverse,
	output logic                status
);
	logic [OPBITS-1:0] r_q, nr_q, t_q, nt_q, n_q;
	logic              t_neg_q, nt_neg_q;
	logic [OPBITS-1:0] dvd_q, rem_q, prod_q;
	logic              rsp_valid_q, status_q;
	logic [OPBITS-1:0] inverse_q;

	logic [OPBITS:0]   shifted;
	logic [OPBITS+1:0] diff;
	logic              qbit;
	logic [OPBITS-1:0] prod_nxt, mag, inv_nxt;
	logic              st_nxt;

	// restoring division step
	assign shifted  = {rem_q, dvd_q[OPBITS-1]};
	assign diff     = {1'b0, shifted} - {2'b00, nr_q};
	assign qbit     = ~diff[OPBITS+1];
	assign prod_nxt = {prod_q[OPBITS-2:0], 1'b0} + (qbit ? nt_q : '0);
	// coefficients alternate in sign, so the new magnitude is a sum
	assign mag      = t_q + prod_q;

	always_comb begin
		st_nxt  = (r_q != OPBITS'(1));
		inv_nxt = '0;
		if (!st_nxt) begin
			if (t_neg_q && t_q != '0) begin
				inv_nxt = n_q - t_q;
			end else begin
				inv_nxt = t_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q      <= modulus;
			nr_q     <= value;
			n_q      <= modulus;
			t_q      <= '0;
			nt_q     <= OPBITS'(1);
			t_neg_q  <= 1'b0;
			nt_neg_q <= 1'b0;
		end else if (cmd.commit) begin
			t_q      <= nt_q;
			t_neg_q  <= nt_neg_q;
			nt_q     <= mag;
			nt_neg_q <= ~nt_neg_q;
			r_q      <= nr_q;
			nr_q     <= rem_q;
		end
		if (cmd.div_init) begin
			dvd_q  <= r_q;
			rem_q  <= '0;
			prod_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[OPBITS-2:0], qbit};
			rem_q  <= qbit ? diff[OPBITS-1:0] : shifted[OPBITS-1:0];
			prod_q <= prod_nxt;
		end
		if (cmd.emit) begin
			inverse_q <= inv_nxt;
			status_q  <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.nr_zero  = (nr_q == '0);
	assign sts.out_free = ~rsp_valid_q | rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign inverse      = inverse_q;
	assign status       = status_q;

`ifndef SYNTH
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp_valid_q || rsp_ready))
		else $error("result written over an untaken transfer");
	a_commit_nz: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> nr_q != '0)
		else $error("quotient step committed with zero divisor");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> rsp_valid_q)
		else $error("emitted result not presented");
`endif
endmodule

>>> rtl/mi_ctrl.sv
// mi_ctrl: sequencer for quotient steps and bit-serial division
// depends on mi_pkg

module mi_ctrl #(
	parameter int OPBITS = 31
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output mi_pkg::mi_cmd_t cmd,
	input  mi_pkg::mi_sts_t sts
);
	localparam int CW = $clog2(OPBITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sts.nr_zero) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
						cnt_q   <= CW'(OPBITS - 1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_COMMIT: begin
					state_q <= ST_CHECK;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && req_valid;
		cmd.div_init = (state_q == ST_CHECK) && !sts.nr_zero;
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_COMMIT);
		cmd.emit     = (state_q == ST_EMIT) && sts.out_free;
	end

	assign req_ready = (state_q == ST_IDLE);

`ifndef SYNTH
	a_commit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |-> $past(state_q) == ST_DIV)
		else $error("commit without a finished division");
	a_div_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |=> state_q == ST_DIV && cnt_q == CW'(OPBITS - 1))
		else $error("division did not start with a full bit count");
	a_load_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_CHECK)
		else $error("accepted pair not processed");
`endif
endmodule

>>> rtl/modular_inverse_core.sv
// modular_inverse_core: top level of the extended Euclidean modular inverse block
// depends on mi_pkg, mi_in_if, mi_out_if, mi_ctrl, mi_datapath
//
// usage:
//  - req channel (valid/ready) carries value and modulus, WIDTH-1 bits each, unsigned
//  - rsp channel (valid/ready) carries inverse (WIDTH-1 bits) and status
//    (0 inverse found, 1 value and modulus not coprime, inverse then reads zero)
//  - one item is worked at a time; req.ready is high only while the core is idle
//  - every quotient step runs a remainder check, then restoring division
//    (one quotient bit per cycle, the quotient times coefficient product accumulated
//    alongside) and then an update of the remainder pair and coefficients
//  - latency from a req transfer to rsp.valid grows with the step count and is set
//    by the shared bit-serial divider
//  - the next req transfer is taken only after the previous result has been
//    written to the output register
//  - the result sits in an output register, so the next req transfer can be taken
//    while rsp stalls; a second result waits in the core until that register frees
//  - arst_n clears the controller and the output valid; no result is pending after reset

module modular_inverse_core #(
	parameter int WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	mi_in_if.sink    req,
	mi_out_if.source rsp
);
	localparam int OPBITS = WIDTH - 1;

	mi_pkg::mi_cmd_t cmd;
	mi_pkg::mi_sts_t sts;

	// sequencer: steps, division bit count, result hand-off
	mi_ctrl #(
		.OPBITS (OPBITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// remainder pair, signed coefficients, divider and output register
	mi_datapath #(
		.OPBITS (OPBITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (req.value),
		.modulus   (req.modulus),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.inverse   (rsp.inverse),
		.status    (rsp.status)
	);
endmodule
